FILE: rtl/core/alsd_pkg.sv
`timescale 1ns / 1ps
// Package for the shift-delete array list: sizes, operation and status codes,
// request, response and cell control types. Depends on nothing.
package alsd_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int NXT_W      = $clog2(LIST_DEPTH + 2);
    localparam int DATA_W     = 32;
    localparam int ICNT_W     = 5;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_FIRST  = 2'd2,
        FN_NEXT   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_END      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic                     is_empty;
        logic [ICNT_W-1:0]        item_count;
    } t_rsp;

    // Control broadcast to every cell of the list.
    typedef struct packed {
        logic                     capture;
        logic                     ins;
        logic                     shift;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

FILE: rtl/core/alsd_cell.sv
`timescale 1ns / 1ps
// One storage cell of the shift-delete list: holds a word and its match flag.
// Depends on alsd_pkg.
module alsd_cell (
    input  logic                              i_clk,
    input  logic [alsd_pkg::IDX_W-1:0]        i_index,
    input  alsd_pkg::t_cell_ctl               i_ctl,
    input  logic                              i_hit_below,
    input  logic signed [alsd_pkg::DATA_W-1:0] i_next_entry,
    output logic                              o_hit_upto,
    output logic signed [alsd_pkg::DATA_W-1:0] o_entry
);

    logic signed [alsd_pkg::DATA_W-1:0] r_entry;
    logic                               r_match;
    logic [alsd_pkg::CNT_W-1:0]         w_pos;

    assign w_pos      = alsd_pkg::CNT_W'(i_index);
    assign o_hit_upto = i_hit_below | r_match;
    assign o_entry    = r_entry;

    // The match flag only counts for occupied positions.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= (r_entry == i_ctl.value) && (w_pos < i_ctl.count);
        end
    end

    // From the first match upwards every cell takes its upper neighbour's word.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (w_pos == i_ctl.count)) begin
            r_entry <= i_ctl.value;
        end else if (i_ctl.shift && o_hit_upto) begin
            r_entry <= i_next_entry;
        end
    end

endmodule

FILE: rtl/core/array_list_shift_delete_unit.sv
`timescale 1ns / 1ps
// Top level of the shift-delete array list: control, cursor and response
// register around a chain of alsd_cell instances. Depends on alsd_pkg.
//
// This block keeps an ordered list of up to LIST_DEPTH signed 32-bit words in
// a row of cells, together with a read cursor. Each request carries an
// operation: insert appends at the tail, remove deletes the first word equal
// to the value and closes the gap, first and next walk the list. Every
// request yields exactly one response with a status, the word read (minus one
// at end of list, zero for insert and remove), the empty flag and the count.
// Once a request is accepted every cell compares its word with the request
// value in parallel and registers its match flag; in the execute state that
// follows, the first match is resolved along the cell chain, the cells shift
// or load, and the response register is loaded. The block then accepts the
// next request at once, but takes no new request while one is executing.
// While a response is held by a stalled consumer, an accepted request waits
// in its execute state and new requests are stalled until it has completed.
module array_list_shift_delete_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  alsd_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output alsd_pkg::t_rsp  o_rsp
);

    localparam int DEPTH = alsd_pkg::LIST_DEPTH;

    alsd_pkg::t_state                    r_state;
    alsd_pkg::t_state                    n_state;
    alsd_pkg::t_func                     r_func;
    logic signed [alsd_pkg::DATA_W-1:0]  r_value;
    logic [alsd_pkg::CNT_W-1:0]          r_count;
    logic [alsd_pkg::CNT_W-1:0]          n_count;
    // Position the next read will look at; the cursor itself plus one.
    logic [alsd_pkg::NXT_W-1:0]          r_nxt;
    logic [alsd_pkg::NXT_W-1:0]          n_nxt;
    logic                                r_rsp_valid;
    alsd_pkg::t_rsp                      r_rsp;
    alsd_pkg::t_rsp                      n_rsp;

    logic                                w_capture;
    logic                                w_fire;
    logic                                w_ins;
    logic                                w_shift;
    logic [alsd_pkg::NXT_W-1:0]          w_pos;
    logic signed [alsd_pkg::DATA_W-1:0]  w_rd_data;
    alsd_pkg::t_cell_ctl                 w_ctl;

    logic                                w_hit [DEPTH+1];
    logic signed [alsd_pkg::DATA_W-1:0]  w_entry [DEPTH];

    // ------------------------------------------------------------------
    // Cell chain. The hit signal ripples upwards from the bottom cell, so
    // each cell knows whether the first match lies at or below it.
    // ------------------------------------------------------------------
    assign w_hit[0] = 1'b0;

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [alsd_pkg::DATA_W-1:0] w_above;
            if (g == DEPTH - 1) begin : g_top
                assign w_above = w_entry[g];
            end else begin : g_mid
                assign w_above = w_entry[g+1];
            end
            alsd_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (alsd_pkg::IDX_W'(g)),
                .i_ctl        (w_ctl),
                .i_hit_below  (w_hit[g]),
                .i_next_entry (w_above),
                .o_hit_upto   (w_hit[g+1]),
                .o_entry      (w_entry[g])
            );
        end
    endgenerate

    assign w_ctl.capture = w_capture;
    assign w_ctl.ins     = w_ins;
    assign w_ctl.shift   = w_shift;
    assign w_ctl.count   = r_count;
    assign w_ctl.value   = (r_state == alsd_pkg::S_IDLE) ? i_req.value : r_value;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alsd_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = alsd_pkg::S_EXEC;
                end
            end
            alsd_pkg::S_EXEC: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_state = alsd_pkg::S_IDLE;
                end
            end
            default: n_state = alsd_pkg::S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        o_req_stall = 1'b0;
        w_capture   = 1'b0;
        w_fire      = 1'b0;
        unique case (r_state)
            alsd_pkg::S_IDLE: begin
                w_capture = i_req_valid;
            end
            alsd_pkg::S_EXEC: begin
                o_req_stall = 1'b1;
                w_fire      = !r_rsp_valid || !i_rsp_stall;
            end
            default: o_req_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Execute state of a request: decide the outcome and the new state.
    // ------------------------------------------------------------------
    assign w_rd_data = w_entry[w_pos[alsd_pkg::IDX_W-1:0]];

    always_comb begin
        n_count          = r_count;
        n_nxt            = r_nxt;
        w_ins            = 1'b0;
        w_shift          = 1'b0;
        w_pos            = '0;
        n_rsp.status     = alsd_pkg::ST_OK;
        n_rsp.read_value = '0;
        unique case (r_func)
            alsd_pkg::FN_INSERT: begin
                if (r_count >= alsd_pkg::CNT_W'(DEPTH)) begin
                    n_rsp.status = alsd_pkg::ST_FULL;
                end else begin
                    w_ins   = w_fire;
                    n_count = r_count + alsd_pkg::CNT_W'(1);
                end
            end
            alsd_pkg::FN_REMOVE: begin
                if (r_count == '0) begin
                    n_rsp.status = alsd_pkg::ST_EMPTY;
                end else if (!w_hit[DEPTH]) begin
                    n_rsp.status = alsd_pkg::ST_NOTFOUND;
                end else begin
                    w_shift = w_fire;
                    n_count = r_count - alsd_pkg::CNT_W'(1);
                end
            end
            alsd_pkg::FN_FIRST, alsd_pkg::FN_NEXT: begin
                w_pos = (r_func == alsd_pkg::FN_FIRST) ? '0 : r_nxt;
                if (w_pos >= alsd_pkg::NXT_W'(r_count)) begin
                    // Past the tail: the cursor parks one beyond the last word.
                    n_rsp.status     = alsd_pkg::ST_END;
                    n_rsp.read_value = '1;
                    n_nxt            = alsd_pkg::NXT_W'(r_count) + alsd_pkg::NXT_W'(1);
                end else begin
                    n_rsp.read_value = w_rd_data;
                    n_nxt            = w_pos + alsd_pkg::NXT_W'(1);
                end
            end
            default: n_rsp.status = alsd_pkg::ST_OK;
        endcase
        n_rsp.is_empty   = (n_count == '0);
        n_rsp.item_count = alsd_pkg::ICNT_W'(n_count);
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alsd_pkg::S_IDLE;
            r_count     <= '0;
            r_nxt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_nxt       <= n_nxt;
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_func  <= alsd_pkg::t_func'(i_req.func);
            r_value <= i_req.value;
        end
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= alsd_pkg::CNT_W'(DEPTH))
        else $error("list count exceeds the depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> (r_state == alsd_pkg::S_EXEC))
        else $error("accepted request did not enter its second cycle");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_func == alsd_pkg::FN_INSERT && r_count < alsd_pkg::CNT_W'(DEPTH))
        |=> (r_count == $past(r_count) + alsd_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");

    a_remove_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_func == alsd_pkg::FN_REMOVE && r_count != '0 && w_hit[DEPTH])
        |=> (r_count == $past(r_count) - alsd_pkg::CNT_W'(1)))
        else $error("remove with a match did not shrink the list");

    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == alsd_pkg::S_EXEC))
        else $error("response appeared without a request being completed");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_list_shift_delete_unit: a directed opening
// and random operation sequences, checked against an in-bench list predictor.
// Depends on alsd_pkg and the RTL of the list unit.
module tb;

    import alsd_pkg::*;

    // Request count for the random part, on top of the directed opening.
    localparam int RANDOM_OPS   = 600;
    // Length of the one long hold-off on the response side, in cycles.
    localparam int LONG_HOLD    = 300;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_req_valid = 1'b0;
    t_req   i_req       = '0;
    logic   i_rsp_stall = 1'b0;
    logic   o_req_stall;
    logic   o_rsp_valid;
    t_rsp   o_rsp;

    array_list_shift_delete_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Requests waiting to be offered, and the responses that accepted
    // requests are owed, oldest first.
    t_req pending_ops[$];
    t_rsp due_responses[$];

    // Contents of the list as the stimulus generator tracks it, so that
    // removals can name words that are really present.
    logic [DATA_W-1:0] gen_list[$];

    // Predicted state of the unit: the words in order, how many there are
    // and the read cursor, which starts one place before the first word.
    logic [DATA_W-1:0] list_words [LIST_DEPTH];
    int                list_count = 0;
    int                walk_pos   = -1;

    int mismatches  = 0;
    int reqs_taken  = 0;
    int rsp_seen    = 0;
    int total_ops   = 0;

    // Sender burst and gap counters.
    int burst_left;
    int gap_left;

    // Receiver stall pattern and the long hold-off.
    int stall_mode;
    int phase_left;
    int hold_left;
    bit hold_done;

    t_rsp want;

    // Works out the response to one request and updates the predicted list.
    function automatic t_rsp predict_list_op(t_req req);
        t_rsp rsp;
        int   idx;
        int   hit;
        rsp = '0;
        rsp.status = ST_OK;
        case (req.func)
            FN_INSERT: begin
                if (list_count >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_words[list_count] = req.value;
                    list_count++;
                end
            end
            FN_REMOVE: begin
                if (list_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    hit = -1;
                    for (idx = 0; idx < list_count && hit < 0; idx++)
                        if (list_words[idx] == req.value)
                            hit = idx;
                    if (hit < 0) begin
                        rsp.status = ST_NOTFOUND;
                    end else begin
                        // Close the gap; the cursor is left where it was.
                        for (idx = hit; idx + 1 < list_count; idx++)
                            list_words[idx] = list_words[idx + 1];
                        list_count--;
                    end
                end
            end
            default: begin
                if (req.func == FN_FIRST)
                    walk_pos = -1;
                if (walk_pos + 1 >= list_count) begin
                    // Past the tail the cursor saturates at the count.
                    walk_pos        = list_count;
                    rsp.status      = ST_END;
                    rsp.read_value  = '1;
                end else begin
                    walk_pos++;
                    rsp.read_value = list_words[walk_pos];
                end
            end
        endcase
        rsp.is_empty   = (list_count == 0);
        rsp.item_count = list_count[ICNT_W-1:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] exp_word);
        $display("response %0d: %s is %h, predicted %h", rsp_seen, what, got, exp_word);
        mismatches++;
    endtask

    // Queues one request and keeps the generator's view of the list in step.
    task automatic push_op(t_func fn, logic [DATA_W-1:0] word);
        t_req r;
        int   k;
        bit   hit;
        r.func  = fn;
        r.value = word;
        pending_ops.push_back(r);
        hit = 1'b0;
        if (fn == FN_INSERT && gen_list.size() < LIST_DEPTH) begin
            gen_list.push_back(word);
        end else if (fn == FN_REMOVE) begin
            for (k = 0; k < gen_list.size() && !hit; k++) begin
                if (gen_list[k] == word) begin
                    gen_list.delete(k);
                    hit = 1'b1;
                end
            end
        end
    endtask

    // A word biased towards the extremes and towards small values, so that
    // duplicates are common; the rest is uniform over all 32 bits.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2:    return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // A word currently held in the list, where there is one.
    function automatic logic [DATA_W-1:0] present_word();
        if (gen_list.size() == 0)
            return pick_word();
        return gen_list[$urandom_range(0, gen_list.size() - 1)];
    endfunction

    // Sender: offers requests in bursts of random length, with random gaps
    // between them.  A stalled request is held unchanged until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            i_req       <= '0;
            burst_left  <= $urandom_range(1, 40);
            gap_left    <= 0;
        end else begin
            if (i_req_valid && !o_req_stall) begin
                due_responses.push_back(predict_list_op(i_req));
                reqs_taken++;
            end
            if (!(i_req_valid && o_req_stall)) begin
                if (gap_left != 0) begin
                    gap_left    <= gap_left - 1;
                    i_req_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    i_req_valid <= 1'b1;
                    i_req       <= pending_ops.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // Some bursts run straight into the next one.
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on a pattern that changes density from phase to
    // phase.  Once, part way through, it holds off for a long stretch while
    // the sender keeps offering, so that the unit fills and stalls requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
            stall_mode  <= 0;
            phase_left  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_rsp_stall <= 1'b1;
        end else if (!hold_done && rsp_seen >= 150) begin
            hold_done   <= 1'b1;
            hold_left   <= LONG_HOLD - 1;
            i_rsp_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                phase_left <= $urandom_range(10, 60);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_mode)
                0:       i_rsp_stall <= 1'b0;
                1:       i_rsp_stall <= ($urandom_range(0, 3) == 0);
                2:       i_rsp_stall <= $urandom_range(0, 1);
                default: i_rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: every response taken is compared with the oldest prediction,
    // field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (due_responses.size() == 0) begin
                report_mismatch("unexpected response, status",
                                DATA_W'(o_rsp.status), '0);
            end else begin
                want = due_responses.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", DATA_W'(o_rsp.status),
                                    DATA_W'(want.status));
                if (o_rsp.read_value !== want.read_value)
                    report_mismatch("read_value", o_rsp.read_value, want.read_value);
                if (o_rsp.is_empty !== want.is_empty)
                    report_mismatch("is_empty", DATA_W'(o_rsp.is_empty),
                                    DATA_W'(want.is_empty));
                if (o_rsp.item_count !== want.item_count)
                    report_mismatch("item_count", DATA_W'(o_rsp.item_count),
                                    DATA_W'(want.item_count));
            end
            rsp_seen++;
        end
    end

    initial begin
        int kind;
        int k;
        int j;

        // Directed opening.  Reads and a removal on the empty list come
        // first, then words at the extremes with a duplicate, removal of the
        // first of two equal words and of an absent word, a walk that runs
        // off the tail and stays there, and removals under a live cursor
        // that leave it beyond the new tail.
        push_op(FN_FIRST,  $urandom());
        push_op(FN_NEXT,   $urandom());
        push_op(FN_REMOVE, 32'h0000_0005);
        push_op(FN_INSERT, 32'h8000_0000);
        push_op(FN_INSERT, 32'h7fff_ffff);
        push_op(FN_INSERT, 32'hffff_ffff);
        push_op(FN_INSERT, 32'h0000_0000);
        push_op(FN_INSERT, 32'h7fff_ffff);
        push_op(FN_REMOVE, 32'h7fff_ffff);
        push_op(FN_REMOVE, 32'h1234_5678);
        push_op(FN_FIRST,  $urandom());
        for (k = 0; k < 5; k++)
            push_op(FN_NEXT, $urandom());
        push_op(FN_FIRST,  $urandom());
        push_op(FN_NEXT,   $urandom());
        push_op(FN_NEXT,   $urandom());
        push_op(FN_REMOVE, 32'h8000_0000);
        push_op(FN_REMOVE, 32'hffff_ffff);
        push_op(FN_NEXT,   $urandom());
        push_op(FN_REMOVE, 32'h7fff_ffff);
        push_op(FN_REMOVE, 32'h0000_0000);

        // The random part opens by filling the list and inserting past full.
        while (gen_list.size() < LIST_DEPTH)
            push_op(FN_INSERT, pick_word());
        push_op(FN_INSERT, pick_word());

        // Random sequences, mostly well formed: fills, drains of words that
        // are present, full walks, walks broken by a removal, and some noise.
        total_ops = pending_ops.size() + RANDOM_OPS;
        while (pending_ops.size() < total_ops) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    k = LIST_DEPTH - gen_list.size() + $urandom_range(0, 2);
                    if ($urandom_range(0, 1) == 0)
                        k = $urandom_range(1, k);
                    for (j = 0; j < k; j++)
                        push_op(FN_INSERT,
                                ($urandom_range(0, 3) == 0) ? present_word() : pick_word());
                end
                3, 4: begin
                    k = $urandom_range(1, LIST_DEPTH + 2);
                    for (j = 0; j < k; j++)
                        push_op(FN_REMOVE,
                                ($urandom_range(0, 9) < 7) ? present_word() : pick_word());
                end
                5, 6: begin
                    push_op(FN_FIRST, $urandom());
                    k = gen_list.size() + $urandom_range(0, 2);
                    for (j = 0; j < k; j++)
                        push_op(FN_NEXT, $urandom());
                end
                7: begin
                    push_op(FN_FIRST, $urandom());
                    k = $urandom_range(0, gen_list.size());
                    for (j = 0; j < k; j++)
                        push_op(FN_NEXT, $urandom());
                    push_op(FN_REMOVE, present_word());
                    for (j = 0; j < 3; j++)
                        push_op(FN_NEXT, $urandom());
                end
                default: begin
                    k = $urandom_range(1, 6);
                    for (j = 0; j < k; j++)
                        push_op(t_func'($urandom_range(0, 3)), pick_word());
                end
            endcase
        end
        total_ops = pending_ops.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken != total_ops)
            @(posedge i_clk);
        while (due_responses.size() != 0)
            @(posedge i_clk);
        // Wait on to catch any response the unit should not give.
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // This watchdog gives up well after the slowest correct run should have ended.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: array_list_shift_delete_unit.f
rtl/core/alsd_pkg.sv
rtl/core/alsd_cell.sv
rtl/core/array_list_shift_delete_unit.sv
verif/tb.sv
